// ===== rtl/ifpr_pkg.sv =====
`timescale 1ns / 1ps

package ifpr_pkg;

   // byte store geometry
   localparam int BUF_DEPTH = 64;
   localparam int ADDR_W    = $clog2(BUF_DEPTH);

   // commands
   localparam logic [1:0] CMD_BYTE = 2'd0;
   localparam logic [1:0] CMD_TICK = 2'd1;
   localparam logic [1:0] CMD_ACK  = 2'd2;
   localparam logic [1:0] CMD_READ = 2'd3;

   // error codes
   localparam logic [1:0] ERR_NONE            = 2'd0;
   localparam logic [1:0] ERR_FRAMING         = 2'd1;
   localparam logic [1:0] ERR_OVERRUN         = 2'd2;
   localparam logic [1:0] ERR_READ_INCOMPLETE = 2'd3;

   // register indexes
   localparam logic [7:0] CSR_IDLE_LIMIT = 8'd0;
   localparam logic [7:0] CSR_CRC_CHECK  = 8'd1;

   // byte store port group
   typedef struct packed {
      logic              wr_en;
      logic              flush;
      logic [ADDR_W-1:0] wr_addr;
      logic [7:0]        wr_data;
      logic [ADDR_W-1:0] rd_addr;
   } st_ctl_type;

   // crc unit control
   typedef struct packed {
      logic       clear;
      logic       enable;
      logic [7:0] data;
   } crc_ctl_type;

endpackage

// ===== rtl/ifpr_store.sv =====
`timescale 1ns / 1ps

// Packet byte store: one write and one registered read per cycle.
// Per-entry valid bits give the all-zero flush.
module ifpr_store import ifpr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  st_ctl_type ctl,
   output logic [7:0] rd_data
);

   logic [7:0]           mem_ff [BUF_DEPTH];
   logic [BUF_DEPTH-1:0] valid_ff, valid_in;
   logic [7:0]           q_ff;
   logic                 q_vld_ff;

   always_comb begin
      valid_in = valid_ff;
      if (ctl.flush) begin
         valid_in = '0;
      end else if (ctl.wr_en) begin
         valid_in[ctl.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         q_vld_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         q_vld_ff <= valid_ff[ctl.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[ctl.wr_addr] <= ctl.wr_data;
      end
      q_ff <= mem_ff[ctl.rd_addr];
   end

   // never-written or flushed entries read as zero
   assign rd_data = q_vld_ff ? q_ff : 8'd0;

endmodule

// ===== rtl/ifpr_crc_unit.sv =====
`timescale 1ns / 1ps

// CRC-16/XMODEM accumulator, one byte per enabled cycle.
module ifpr_crc_unit import ifpr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  crc_ctl_type ctl,
   output logic [15:0] crc
);

   localparam logic [15:0] CRC_POLY = 16'h1021;

   logic [15:0] crc_ff, crc_in;

   function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] octet);
      logic [15:0] r;
      r = c ^ {octet, 8'd0};
      for (int b = 0; b < 8; b++) begin
         if (r[15]) begin
            r = {r[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            r = {r[14:0], 1'b0};
         end
      end
      return r;
   endfunction

   always_comb begin
      crc_in = crc_ff;
      if (ctl.clear) begin
         crc_in = '0;
      end else if (ctl.enable) begin
         crc_in = crc16_byte(crc_ff, ctl.data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= '0;
      end else begin
         crc_ff <= crc_in;
      end
   end

   assign crc = crc_ff;

endmodule

// ===== rtl/idle_framed_packet_receiver_crc16.sv =====
`timescale 1ns / 1ps
// Sequence: byte, tick and acknowledge words pass from start through EXEC to RESP, a buffer read
//    also through RDWAIT; a tick that closes a packet of more than 2 bytes goes WALK, DECIDE, RESP.
// A new word is taken only once busy drops; the close walks the store one byte a cycle through
//    the single read port and the CRC unit.
// Reset: synchronous, active high; clears control state but not payload registers, sets read_done,
//    idle_limit to 500, crc check on. The result strobe lasts one cycle and cannot be stalled.
module idle_framed_packet_receiver_crc16 import ifpr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // request word
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_rx_byte,
   input  logic [1:0]  req_line_error,
   input  logic [5:0]  req_read_index,
   // result word
   output logic        rsp_valid,
   output logic [7:0]  rsp_read_data,
   output logic [7:0]  rsp_last_byte,
   output logic [5:0]  rsp_packet_length,
   output logic        rsp_data_available,
   output logic        rsp_read_done,
   output logic        rsp_crc_ok,
   output logic [15:0] rsp_crc_computed,
   output logic [15:0] rsp_crc_received,
   output logic [1:0]  rsp_sticky_error,
   output logic        rsp_packet_closed,
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [23:0] csr_wdata
);

   localparam logic [23:0] IDLE_LIMIT_RST = 24'd500;

   // sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_EXEC   = 3'd1;
   localparam logic [2:0] ST_RDWAIT = 3'd2;
   localparam logic [2:0] ST_WALK   = 3'd3;
   localparam logic [2:0] ST_DECIDE = 3'd4;
   localparam logic [2:0] ST_RESP   = 3'd5;

   logic [2:0]        state_ff, state_in;
   // latched request word
   logic [1:0]        cmd_ff, cmd_in;
   logic [7:0]        byte_ff, byte_in;
   logic [1:0]        lerr_ff, lerr_in;
   logic [5:0]        idx_ff, idx_in;
   // receiver state
   logic [ADDR_W-1:0] wpos_ff, wpos_in;
   logic [7:0]        last_ff, last_in;
   logic [23:0]       idle_cnt_ff, idle_cnt_in;
   logic              idle_run_ff, idle_run_in;
   logic              avail_ff, avail_in;
   logic              ack_ff, ack_in;
   logic              check_ff, check_in;
   logic [15:0]       comp_ff, comp_in;
   logic [15:0]       rcv_ff, rcv_in;
   logic [1:0]        ferr_ff, ferr_in;
   logic              closed_ff, closed_in;
   logic [7:0]        rd_data_ff, rd_data_in;
   // registers
   logic [23:0]       limit_ff, limit_in;
   logic              crc_on_ff, crc_on_in;
   // store walk
   logic [ADDR_W-1:0] ptr_ff, ptr_in;
   logic              dv_ff, dv_in;
   logic [ADDR_W-1:0] didx_ff, didx_in;
   logic [7:0]        hi_ff, hi_in;
   logic [7:0]        lo_ff, lo_in;

   st_ctl_type        st_ctl;
   crc_ctl_type       crc_ctl;
   logic [7:0]        st_q;
   logic [15:0]       crc_q;
   logic [23:0]       cnt_inc;
   logic [ADDR_W-1:0] body_len;
   logic              long_pkt;
   logic              crc_match;

   ifpr_store u_store (
      .clock   (clock),
      .reset   (reset),
      .ctl     (st_ctl),
      .rd_data (st_q)
   );

   ifpr_crc_unit u_crc (
      .clock (clock),
      .reset (reset),
      .ctl   (crc_ctl),
      .crc   (crc_q)
   );

   assign cnt_inc   = idle_cnt_ff + 24'd1;
   assign long_pkt  = (wpos_ff > ADDR_W'(2));
   assign body_len  = wpos_ff - ADDR_W'(2);
   assign crc_match = (crc_q == {hi_ff, lo_ff});

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      byte_in     = byte_ff;
      lerr_in     = lerr_ff;
      idx_in      = idx_ff;
      wpos_in     = wpos_ff;
      last_in     = last_ff;
      idle_cnt_in = idle_cnt_ff;
      idle_run_in = idle_run_ff;
      avail_in    = avail_ff;
      ack_in      = ack_ff;
      check_in    = check_ff;
      comp_in     = comp_ff;
      rcv_in      = rcv_ff;
      ferr_in     = ferr_ff;
      closed_in   = closed_ff;
      rd_data_in  = rd_data_ff;
      limit_in    = limit_ff;
      crc_on_in   = crc_on_ff;
      ptr_in      = ptr_ff;
      dv_in       = 1'b0;
      didx_in     = didx_ff;
      hi_in       = hi_ff;
      lo_in       = lo_ff;

      st_ctl         = '0;
      st_ctl.wr_addr = wpos_ff;
      st_ctl.wr_data = byte_ff;
      st_ctl.rd_addr = ADDR_W'(idx_ff);
      crc_ctl        = '0;
      crc_ctl.data   = st_q;

      // register writes are taken in any state
      if (csr_valid) begin
         case (csr_index)
            CSR_IDLE_LIMIT: limit_in  = csr_wdata;
            CSR_CRC_CHECK:  crc_on_in = csr_wdata[0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in     = req_command;
               byte_in    = req_rx_byte;
               lerr_in    = req_line_error;
               idx_in     = req_read_index;
               rd_data_in = 8'd0;
               closed_in  = 1'b0;
               state_in   = ST_EXEC;
            end
         end

         ST_EXEC: begin
            state_in = ST_RESP;
            unique case (cmd_ff)
               CMD_BYTE: begin
                  if (lerr_ff == ERR_NONE) begin
                     st_ctl.wr_en = 1'b1;
                     last_in      = byte_ff;
                     wpos_in      = (wpos_ff == ADDR_W'(BUF_DEPTH - 1)) ? '0 : wpos_ff + 1'b1;
                  end else begin
                     last_in = 8'd0;
                     if (ferr_ff == ERR_NONE) begin
                        // line error 3 counts as overrun
                        ferr_in = (lerr_ff == ERR_FRAMING) ? ERR_FRAMING : ERR_OVERRUN;
                     end
                  end
                  idle_cnt_in = '0;
                  idle_run_in = 1'b1;
               end
               CMD_TICK: begin
                  if (idle_run_ff) begin
                     idle_cnt_in = cnt_inc;
                     if (cnt_inc >= limit_ff) begin
                        idle_run_in = 1'b0;
                        idle_cnt_in = '0;
                        if (wpos_ff != '0) begin
                           if (!ack_ff && ferr_ff == ERR_NONE) begin
                              ferr_in = ERR_READ_INCOMPLETE;
                           end
                           crc_ctl.clear = 1'b1;
                           ptr_in        = '0;
                           state_in      = long_pkt ? ST_WALK : ST_DECIDE;
                        end
                     end
                  end
               end
               CMD_ACK: begin
                  st_ctl.flush = 1'b1;
                  wpos_in      = '0;
                  avail_in     = 1'b0;
                  ack_in       = 1'b1;
               end
               CMD_READ: begin
                  state_in = ST_RDWAIT;
               end
               default: ;
            endcase
         end

         ST_RDWAIT: begin
            rd_data_in = (int'(idx_ff) < BUF_DEPTH) ? st_q : 8'd0;
            state_in   = ST_RESP;
         end

         // issue one read a cycle; data returns in the next cycle tagged by didx
         ST_WALK: begin
            st_ctl.rd_addr = ptr_ff;
            if (ptr_ff != wpos_ff) begin
               ptr_in = ptr_ff + 1'b1;
               dv_in  = 1'b1;
            end
            didx_in = ptr_ff;
            if (dv_ff) begin
               if (didx_ff < body_len) begin
                  crc_ctl.enable = 1'b1;
               end else if (didx_ff == body_len) begin
                  hi_in = st_q;
               end else begin
                  lo_in    = st_q;
                  state_in = ST_DECIDE;
               end
            end
         end

         ST_DECIDE: begin
            // short packet: crc_ok drops, CRC registers hold
            if (long_pkt) begin
               comp_in  = crc_q;
               rcv_in   = {hi_ff, lo_ff};
               check_in = crc_match;
            end else begin
               check_in = 1'b0;
            end
            if (!crc_on_ff || (long_pkt && crc_match)) begin
               avail_in = 1'b1;
               ack_in   = 1'b0;
            end else begin
               st_ctl.flush = 1'b1;
               wpos_in      = '0;
               avail_in     = 1'b0;
               ack_in       = 1'b1;
            end
            closed_in = 1'b1;
            state_in  = ST_RESP;
         end

         ST_RESP: begin
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         wpos_ff     <= '0;
         last_ff     <= '0;
         idle_cnt_ff <= '0;
         idle_run_ff <= 1'b0;
         avail_ff    <= 1'b0;
         ack_ff      <= 1'b1;
         check_ff    <= 1'b0;
         comp_ff     <= '0;
         rcv_ff      <= '0;
         ferr_ff     <= ERR_NONE;
         closed_ff   <= 1'b0;
         rd_data_ff  <= '0;
         limit_ff    <= IDLE_LIMIT_RST;
         crc_on_ff   <= 1'b1;
         ptr_ff      <= '0;
         dv_ff       <= 1'b0;
      end else begin
         state_ff    <= state_in;
         wpos_ff     <= wpos_in;
         last_ff     <= last_in;
         idle_cnt_ff <= idle_cnt_in;
         idle_run_ff <= idle_run_in;
         avail_ff    <= avail_in;
         ack_ff      <= ack_in;
         check_ff    <= check_in;
         comp_ff     <= comp_in;
         rcv_ff      <= rcv_in;
         ferr_ff     <= ferr_in;
         closed_ff   <= closed_in;
         rd_data_ff  <= rd_data_in;
         limit_ff    <= limit_in;
         crc_on_ff   <= crc_on_in;
         ptr_ff      <= ptr_in;
         dv_ff       <= dv_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      byte_ff <= byte_in;
      lerr_ff <= lerr_in;
      idx_ff  <= idx_in;
      didx_ff <= didx_in;
      hi_ff   <= hi_in;
      lo_ff   <= lo_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   assign rsp_valid          = (state_ff == ST_RESP);
   assign rsp_read_data      = rd_data_ff;
   assign rsp_last_byte      = last_ff;
   assign rsp_packet_length  = 6'(wpos_ff);
   assign rsp_data_available = avail_ff;
   assign rsp_read_done      = ack_ff;
   assign rsp_crc_ok         = check_ff;
   assign rsp_crc_computed   = comp_ff;
   assign rsp_crc_received   = rcv_ff;
   assign rsp_sticky_error   = ferr_ff;
   assign rsp_packet_closed  = closed_ff;

endmodule
